FILE: rtl/ssfm_pkg.sv
package ssfm_pkg;

    // Configuration layout
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int PAT_BYTES = 32;
    localparam int LEN_W     = 6;
    localparam int START_W   = 16;
    localparam int IDX_W     = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_PATTERN0 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PATTERN1 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PATTERN2 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PATTERN3 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LENGTH   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ICASE    = 3'd5;

    // Item opcodes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Control shared by every window cell
    typedef struct packed {
        logic shift_en;
        logic clear;
        logic ignore_case;
    } cell_ctrl_t;

    // C-locale lower-case fold, only when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: rtl/ssfm_cell.sv
module ssfm_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssfm_pkg::cell_ctrl_t  ctrl,
    input  logic [7:0]            byte_in,
    input  logic [7:0]            pat_byte,
    input  logic                  pat_used,
    output logic [7:0]            byte_out,
    output logic                  hit
);
    import ssfm_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Window byte: cleared at end of text, shifted in from the newer neighbor
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (ctrl.shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    // Compare the byte arriving here with its aligned pattern byte
    assign hit = !pat_used ||
                 (fold_byte(byte_in, ctrl.ignore_case) == fold_byte(pat_byte, ctrl.ignore_case));

endmodule

FILE: rtl/ssfm_align.sv
module ssfm_align #(
    parameter int PATTERN_MAX = 32
) (
    input  logic [ssfm_pkg::PAT_BYTES*8-1:0] pattern_bits,
    input  logic [ssfm_pkg::LEN_W-1:0]       len,
    output logic [PATTERN_MAX*8-1:0]         aligned,
    output logic [PATTERN_MAX-1:0]           used,
    output logic                             active
);
    import ssfm_pkg::*;

    localparam int PM_W = $clog2(PATTERN_MAX + 1);
    localparam int LW   = (PM_W > LEN_W) ? PM_W : LEN_W;

    logic [PATTERN_MAX*8-1:0] pvec;
    logic [LW-1:0]            len_ext;
    logic [LW-1:0]            pm_c;
    logic [LW-1:0]            shamt;
    logic                     len_ok;

    // Pattern bytes past the register file read as zero
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_pvec
        if (k < PAT_BYTES)
        begin : g_reg
            assign pvec[k*8 +: 8] = pattern_bits[k*8 +: 8];
        end
        else
        begin : g_zero
            assign pvec[k*8 +: 8] = 8'h00;
        end
    end

    assign len_ext = LW'(len);
    assign pm_c    = LW'(PATTERN_MAX);
    assign len_ok  = (len_ext <= pm_c);
    assign shamt   = pm_c - len_ext;
    assign active  = len_ok && (len != '0);

    // Pattern byte 0 lines up with the oldest window byte in use
    assign aligned = pvec << {shamt, 3'b000};

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_used
        assign used[j] = active && (LW'(j) >= shamt);
    end

endmodule

FILE: rtl/substring_search_first_match_unit.sv
// Substring search, first match over a streamed text.
// An end item's result is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle; the window compare runs across the cell
// row in the cycle a text byte shifts in, and a stalled result holds input.
// Reset (rst_n low, asynchronous) clears the config registers, window, text state and out_valid.
module substring_search_first_match_unit #(
    parameter int              PATTERN_MAX = 32,
    parameter longint unsigned TEXT_MAX    = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [7:0]                     text_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [ssfm_pkg::START_W-1:0]   match_start,
    output logic                           overflow,
    input  logic                           cfg_we,
    input  logic [ssfm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ssfm_pkg::WORD_W-1:0]    cfg_wdata
);
    import ssfm_pkg::*;

    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int CW    = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Configuration registers
    logic [WORD_W-1:0] pattern_reg [NUM_WORDS];
    logic [LEN_W-1:0]  len_reg;
    logic              icase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                pattern_reg[w] <= '0;
            end
            len_reg   <= '0;
            icase_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN0: pattern_reg[0] <= cfg_wdata;
                CFG_PATTERN1: pattern_reg[1] <= cfg_wdata;
                CFG_PATTERN2: pattern_reg[2] <= cfg_wdata;
                CFG_PATTERN3: pattern_reg[3] <= cfg_wdata;
                CFG_LENGTH:   len_reg        <= cfg_wdata[LEN_W-1:0];
                CFG_ICASE:    icase_reg      <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // Item handshake
    logic in_fire;
    logic text_fire;
    logic end_fire;

    assign in_ready  = !out_valid || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign text_fire = in_fire && (opcode == OP_TEXT);
    assign end_fire  = in_fire && (opcode == OP_END);

    // Text position
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_inc;
    logic             at_max;
    logic             shift_en;

    assign at_max   = (pos_reg == POS_W'(TEXT_MAX));
    assign shift_en = text_fire && !at_max;
    assign pos_inc  = pos_reg + POS_W'(1);

    // Pattern alignment to the window
    logic [PAT_BYTES*8-1:0]   pattern_bits;
    logic [PATTERN_MAX*8-1:0] aligned;
    logic [PATTERN_MAX-1:0]   used;
    logic                     active;

    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_pat
        assign pattern_bits[w*WORD_W +: WORD_W] = pattern_reg[w];
    end

    ssfm_align #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_align (
        .pattern_bits (pattern_bits),
        .len          (len_reg),
        .aligned      (aligned),
        .used         (used),
        .active       (active)
    );

    // Window cell row, newest byte enters at the top cell
    cell_ctrl_t             cell_ctrl;
    logic [7:0]             cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    assign cell_ctrl.shift_en    = shift_en;
    assign cell_ctrl.clear       = end_fire;
    assign cell_ctrl.ignore_case = icase_reg;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [7:0] feed;
        if (j == PATTERN_MAX - 1)
        begin : g_top
            assign feed = text_byte;
        end
        else
        begin : g_mid
            assign feed = cell_byte[j+1];
        end

        ssfm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .byte_in  (feed),
            .pat_byte (aligned[j*8 +: 8]),
            .pat_used (used[j]),
            .byte_out (cell_byte[j]),
            .hit      (cell_hit[j])
        );
    end

    // Match detect on the window after this shift
    logic          window_hit;
    logic [CW-1:0] pos_inc_ext;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] start_ext;

    assign pos_inc_ext = CW'(pos_inc);
    assign len_ext     = CW'(len_reg);
    assign start_ext   = pos_inc_ext - len_ext;
    assign window_hit  = active && (&cell_hit) && (pos_inc_ext >= len_ext);

    // Text state
    logic               seen_reg;
    logic               seen_next;
    logic [START_W-1:0] idx_reg;
    logic [START_W-1:0] idx_next;
    logic               ovf_reg;
    logic               ovf_next;

    always_comb
    begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        idx_next  = idx_reg;
        ovf_next  = ovf_reg;
        if (end_fire)
        begin
            pos_next  = '0;
            seen_next = 1'b0;
            idx_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (text_fire)
        begin
            if (at_max)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_inc;
                if (!seen_reg && window_hit)
                begin
                    seen_next = 1'b1;
                    idx_next  = START_W'(start_ext);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seen_reg <= 1'b0;
            idx_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            idx_reg  <= idx_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Result register
    logic               out_valid_reg;
    logic               found_reg;
    logic [START_W-1:0] start_reg;
    logic               ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (end_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            if (len_reg == '0)
            begin
                found_reg <= 1'b1;
                start_reg <= '0;
            end
            else
            begin
                found_reg <= seen_reg;
                start_reg <= idx_reg;
            end
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_start = start_reg;
    assign overflow    = ovf_out_reg;

endmodule

FILE: rtl/ssfm_checker.sv
module ssfm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          opcode,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          found,
    input logic [ssfm_pkg::START_W-1:0]  match_start,
    input logic                          overflow
);
    import ssfm_pkg::*;

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(found) && $stable(match_start) && $stable(overflow))
        else $error("result changed while stalled");

    // An accepted end item gives a result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_END) |=> out_valid)
        else $error("end item gave no result");

    // A text item never makes a result appear
    a_text_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_TEXT) && !out_valid |=> !out_valid)
        else $error("text item gave a result");

    // A waiting result blocks the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

bind substring_search_first_match_unit ssfm_checker u_ssfm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_start (match_start),
    .overflow    (overflow)
);
